// ===== hw/rtl/spmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_pkg
// Shared widths, operation codes, stage control and saturating add for the
// sparse-times-dense multiply-accumulate block.
// ----------------------------------------------------------------------------
package spmm_pkg;

  localparam int unsigned OpW        = 2;
  localparam int unsigned ColW       = 10;
  localparam int unsigned SelW       = 2;
  localparam int unsigned ValW       = 32;
  localparam int unsigned RowW       = 20;
  localparam int unsigned RhsW       = 2;
  localparam int unsigned SumW       = 64;
  localparam int unsigned CfgW       = 3;
  localparam int unsigned RecipShift = 20;

  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_NONZERO = 2'd1,
    OP_ROW_END = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } stage_ctl_t;

  // Signed add that clamps at the 64-bit limits
  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW-1:0] s;
    s = a + b;
    if ((a[SumW-1] == b[SumW-1]) && (s[SumW-1] != a[SumW-1])) begin
      s = a[SumW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spmm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_in_if
// Input channel: one operation beat with its column, side and value.
// ----------------------------------------------------------------------------
interface spmm_in_if;
  logic                                valid;
  logic                                ready;
  logic        [spmm_pkg::OpW-1:0]     operation;
  logic        [spmm_pkg::ColW-1:0]    column;
  logic        [spmm_pkg::SelW-1:0]    rhs_select;
  logic signed [spmm_pkg::ValW-1:0]    value;

  modport source (output valid, operation, column, rhs_select, value, input ready);
  modport sink   (input valid, operation, column, rhs_select, value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/spmm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_out_if
// Output channel: one saturated sum beat per right-hand side of a row.
// ----------------------------------------------------------------------------
interface spmm_out_if;
  logic                                valid;
  logic                                ready;
  logic        [spmm_pkg::RowW-1:0]    row;
  logic        [spmm_pkg::RhsW-1:0]    rhs;
  logic signed [spmm_pkg::SumW-1:0]    sum;
  logic                                last;

  modport source (output valid, row, rhs, sum, last, input ready);
  modport sink   (input valid, row, rhs, sum, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csr_sparse_matrix_multivector_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// csr_sparse_matrix_multivector_mac
// Sparse CSR matrix times dense multi-column matrix in Q16.16, sums in Q32.32.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per beat: write a dense entry (column, side,
//   value), stream a nonzero (column, value), or end a row. out_o gives one
//   beat per active right-hand side at each row end, rhs counting up from 0,
//   last set on the final one. cfg_we_i/cfg_wdata_i set the active side
//   count; write it only while the block is idle.
// Timing:
//   One input beat per cycle for writes and nonzeros, sustained while no row
//   end waits for the drain. An item passes a column-reduction stage, a
//   registered dense store read, a product register and the accumulator
//   update; at a row end the sums move into the result buffer. The drain
//   sends one beat per cycle while out_o.ready is high, one per active side;
//   a following row end waits at the accumulator stage and stalls the
//   pipeline until the buffer frees.
// Reset:
//   Clears accumulators, row counter, pipeline valids; side count becomes 1.
//   The dense store is not cleared; write entries before reading them.
// Stall:
//   With out_o.ready low the pipeline keeps taking beats until a row end
//   reaches the drain; then in_i.ready drops and everything holds in place.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_multivector_mac #(
  parameter int unsigned DENSE_ROWS = 1024,
  parameter int unsigned MAX_RHS    = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [spmm_pkg::CfgW-1:0] cfg_wdata_i,
  spmm_in_if.sink                        in_i,
  spmm_out_if.source                     out_o
);

  localparam int unsigned AddrW  = $clog2(DENSE_ROWS);
  localparam int unsigned CntW   = $clog2(MAX_RHS + 1);
  localparam int unsigned ProdW  = spmm_pkg::ColW + spmm_pkg::RecipShift;
  localparam int unsigned Recip  = (1 << spmm_pkg::RecipShift) / DENSE_ROWS;
  localparam logic [ProdW-1:0] RecipK = ProdW'(Recip);
  localparam logic [31:0] RowsK  = 32'(DENSE_ROWS);

  // Configuration and active side count
  logic [spmm_pkg::CfgW-1:0] rhs_count_q;
  logic [CntW-1:0]           n_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhs_count_q <= spmm_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      rhs_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (rhs_count_q == '0) begin
      n_active = CntW'(1);
    end else if (32'(rhs_count_q) > 32'(MAX_RHS)) begin
      n_active = CntW'(MAX_RHS);
    end else begin
      n_active = CntW'(rhs_count_q);
    end
  end

  // Global advance: hold everything while a row end waits for the drain
  logic advance;
  logic row_end;
  logic drain_free;

  assign advance    = !row_end || drain_free;
  assign in_i.ready = advance;

  // Stage 1: estimate quotient of column by the store depth
  logic [ProdW-1:0]              quot_full;
  logic                          s1_valid_q;
  logic [spmm_pkg::OpW-1:0]      s1_op_q;
  logic [spmm_pkg::ColW-1:0]     s1_col_q;
  logic [spmm_pkg::SelW-1:0]     s1_sel_q;
  logic [spmm_pkg::ValW-1:0]     s1_val_q;
  logic [spmm_pkg::ColW-1:0]     s1_quot_q;

  assign quot_full = ProdW'(in_i.column) * RecipK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q   <= in_i.operation;
      s1_col_q  <= in_i.column;
      s1_sel_q  <= in_i.rhs_select;
      s1_val_q  <= in_i.value;
      s1_quot_q <= quot_full[ProdW-1 -: spmm_pkg::ColW];
    end
  end

  // Finish the reduction: estimate is exact or one low
  logic [31:0]      rem_raw;
  logic [31:0]      rem_fix;
  logic [AddrW-1:0] dense_addr;

  assign rem_raw    = 32'(s1_col_q) - (32'(s1_quot_q) * RowsK);
  assign rem_fix    = (rem_raw >= RowsK) ? (rem_raw - RowsK) : rem_raw;
  assign dense_addr = rem_fix[AddrW-1:0];

  // Dense store: one RAM per right-hand side, read together for a nonzero
  logic                                   s1_is_write;
  logic                                   s1_is_nz;
  logic [MAX_RHS-1:0][spmm_pkg::ValW-1:0] dense_rd;

  assign s1_is_write = s1_valid_q && advance &&
                       (spmm_pkg::op_e'(s1_op_q) == spmm_pkg::OP_WRITE);
  assign s1_is_nz    = s1_valid_q && advance &&
                       (spmm_pkg::op_e'(s1_op_q) == spmm_pkg::OP_NONZERO);

  for (genvar g = 0; g < MAX_RHS; g++) begin : g_lane_ram
    logic lane_we;
    assign lane_we = s1_is_write && (32'(s1_sel_q) == 32'(g));

    spmm_ram #(
      .WIDTH (spmm_pkg::ValW),
      .DEPTH (DENSE_ROWS)
    ) u_dense (
      .clk_i   (clk_i),
      .we_i    (lane_we),
      .waddr_i (dense_addr),
      .wdata_i (s1_val_q),
      .re_i    (s1_is_nz),
      .raddr_i (dense_addr),
      .rdata_o (dense_rd[g])
    );
  end

  // Stage 2: dense entries arrive from the RAMs
  spmm_pkg::stage_ctl_t      s2_ctl_q;
  logic [spmm_pkg::ValW-1:0] s2_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '{valid: 1'b0, op: spmm_pkg::OP_NONE};
    end else if (advance) begin
      s2_ctl_q <= '{valid: s1_valid_q, op: spmm_pkg::op_e'(s1_op_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_val_q <= s1_val_q;
    end
  end

  // Stage 3: products and accumulators
  logic [MAX_RHS-1:0][spmm_pkg::SumW-1:0] acc;

  spmm_mac #(
    .MAX_RHS (MAX_RHS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .ctl_i     (s2_ctl_q),
    .val_i     (s2_val_q),
    .dense_i   (dense_rd),
    .n_i       (n_active),
    .row_end_o (row_end),
    .acc_o     (acc)
  );

  // Result buffer and row counter
  spmm_drain #(
    .MAX_RHS (MAX_RHS)
  ) u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (row_end && drain_free),
    .n_i     (n_active),
    .acc_i   (acc),
    .free_o  (drain_free),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/spmm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module spmm_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/spmm_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_mac
// Multiply lanes and saturating accumulators, one lane per right-hand side.
// ----------------------------------------------------------------------------
module spmm_mac #(
  parameter  int unsigned MAX_RHS = 4,
  localparam int unsigned CntW    = $clog2(MAX_RHS + 1)
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      advance_i,
  input  wire spmm_pkg::stage_ctl_t                      ctl_i,
  input  wire logic [spmm_pkg::ValW-1:0]                 val_i,
  input  wire logic [MAX_RHS-1:0][spmm_pkg::ValW-1:0]    dense_i,
  input  wire logic [CntW-1:0]                           n_i,
  output logic                                           row_end_o,
  output logic      [MAX_RHS-1:0][spmm_pkg::SumW-1:0]    acc_o
);

  spmm_pkg::stage_ctl_t          s3_ctl_q;
  logic [spmm_pkg::SumW-1:0]     prod_q [MAX_RHS];
  logic signed [spmm_pkg::SumW-1:0] prod_d [MAX_RHS];
  logic [spmm_pkg::SumW-1:0]     acc_q  [MAX_RHS];
  logic signed [spmm_pkg::ValW-1:0] val_s;

  assign val_s = val_i;

  always_comb begin
    for (int j = 0; j < MAX_RHS; j++) begin
      prod_d[j] = val_s * $signed(dense_i[j]);
    end
  end

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '{valid: 1'b0, op: spmm_pkg::OP_NONE};
    end else if (advance_i) begin
      s3_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int j = 0; j < MAX_RHS; j++) begin
        prod_q[j] <= prod_d[j];
      end
    end
  end

  // Accumulate, or clear when a row end moves on to the drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_RHS; j++) begin
        acc_q[j] <= '0;
      end
    end else if (advance_i && s3_ctl_q.valid) begin
      for (int j = 0; j < MAX_RHS; j++) begin
        if (s3_ctl_q.op == spmm_pkg::OP_ROW_END) begin
          acc_q[j] <= '0;
        end else if (s3_ctl_q.op == spmm_pkg::OP_NONZERO && 32'(j) < 32'(n_i)) begin
          acc_q[j] <= spmm_pkg::sat_add(acc_q[j], prod_q[j]);
        end
      end
    end
  end

  assign row_end_o = s3_ctl_q.valid && (s3_ctl_q.op == spmm_pkg::OP_ROW_END);

  always_comb begin
    for (int j = 0; j < MAX_RHS; j++) begin
      acc_o[j] = acc_q[j];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spmm_drain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmm_drain
// Result buffer: holds a finished row's sums and sends one beat per side.
// ----------------------------------------------------------------------------
module spmm_drain #(
  parameter  int unsigned MAX_RHS = 4,
  localparam int unsigned CntW    = $clog2(MAX_RHS + 1),
  localparam int unsigned IdxW    = (MAX_RHS > 1) ? $clog2(MAX_RHS) : 1
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   load_i,
  input  wire logic [CntW-1:0]                        n_i,
  input  wire logic [MAX_RHS-1:0][spmm_pkg::SumW-1:0] acc_i,
  output logic                                        free_o,
  spmm_out_if.source                                  out_o
);

  logic                          busy_q;
  logic [IdxW-1:0]               idx_q;
  logic [IdxW-1:0]               last_idx_q;
  logic [spmm_pkg::RowW-1:0]     row_q;
  logic [spmm_pkg::RowW-1:0]     row_cnt_q;
  logic [spmm_pkg::SumW-1:0]     sums_q [MAX_RHS];
  logic                          at_last;
  logic                          beat;

  assign at_last = (idx_q == last_idx_q);
  assign beat    = busy_q && out_o.ready;
  assign free_o  = !busy_q || (out_o.ready && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
      row_cnt_q  <= '0;
    end else if (load_i) begin
      busy_q     <= 1'b1;
      idx_q      <= '0;
      last_idx_q <= IdxW'(n_i - CntW'(1));
      row_cnt_q  <= row_cnt_q + spmm_pkg::RowW'(1);
    end else if (beat) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_q <= row_cnt_q;
      for (int j = 0; j < MAX_RHS; j++) begin
        sums_q[j] <= acc_i[j];
      end
    end
  end

  assign out_o.valid = busy_q;
  assign out_o.row   = row_q;
  assign out_o.rhs   = spmm_pkg::RhsW'(idx_q);
  assign out_o.sum   = sums_q[idx_q];
  assign out_o.last  = at_last;

endmodule
`default_nettype wire
